>>> rtl/indexed_ordered_list_defines.svh
// Assertion macros shared by the indexed ordered list RTL.
// Define NO_ASSERTIONS to compile every check away.
`ifndef INDEXED_ORDERED_LIST_DEFINES_SVH
`define INDEXED_ORDERED_LIST_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define IOL_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define IOL_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define IOL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define IOL_ASSERT(label, clk, rst, prop, msg)
`define IOL_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define IOL_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

>>> rtl/iol_pkg.sv
// Shared types and constants of the indexed ordered list.
// No dependencies; imported by indexed_ordered_list, iol_controller and iol_datapath.
`default_nettype none
package iol_pkg;

   localparam int CAPACITY = 16;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int VAL_W    = 32;
   localparam int TYPE_W   = 3;
   localparam int POSA_W   = 5;
   localparam int POSB_W   = 4;
   localparam int REQ_DATA_W = 48;
   localparam int REQ_USER_W = 8;
   localparam int RSP_DATA_W = 48;

   typedef enum logic [TYPE_W-1:0] {
      OP_INSERT  = 3'd0,
      OP_REMOVE  = 3'd1,
      OP_READ    = 3'd2,
      OP_REPLACE = 3'd3,
      OP_SEARCH  = 3'd4,
      OP_COMPARE = 3'd5,
      OP_SWAP    = 3'd6,
      OP_CLEAR   = 3'd7
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_RANGE = 2'd2,
      ST_FULL  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      RS_SHIFT = 2'd0,
      RS_IDX   = 2'd1,
      RS_PA    = 2'd2,
      RS_PB    = 2'd3
   } rd_sel_type;

   typedef enum logic [1:0] {
      WS_SHIFT  = 2'd0,
      WS_PUT    = 2'd1,
      WS_SWAP_A = 2'd2,
      WS_SWAP_B = 2'd3
   } wr_sel_type;

   typedef struct packed {
      logic       load_req;
      logic       decide;
      logic       idx_step;
      rd_sel_type rd_sel;
      logic       wr_en;
      wr_sel_type wr_sel;
      logic       count_inc;
      logic       count_dec;
      logic       count_clr;
      logic       scan_update;
      logic       capture;
      logic       tmp_load;
      logic       out_load;
   } ctrl_cmd_type;

   typedef struct packed {
      op_type op;
      logic   fail;
      logic   shift_go;
      logic   shift_again;
      logic   scan_again;
      logic   out_free;
   } dp_status_type;

endpackage
`default_nettype wire

>>> rtl/indexed_ordered_list.sv
// Indexed ordered list: a bounded positional list of signed 32-bit words.
//
// Input channel req_*: one word per request; req_tuser carries the operation
// (insert, remove, read, replace, search, compare, swap, clear), req_tdata the
// positions and the value. Result channel rsp_*: exactly one word per request
// with status, read data, match flag, entry count and empty flag.
// Requests are handled one at a time. After acceptance a request is decoded
// and checked; clear, a failed request and removal of the last entry then go
// straight to the result, replace writes its entry, read and compare read the
// entry at position_a, swap reads both entries and writes them back crossed,
// insert and remove shift the entries from position_a on, and search scans all.
// The result is loaded into the output register and appears on rsp_* in the
// cycle after that; the next request is taken in the same cycle. The longest
// request is a search of a full list. The shift and scan walks step one entry
// at a time through the entry RAM's single write port and registered read port.
// Reset (synchronous) empties the list and drops any pending result; entry
// contents are left as they are. While rsp_tready is low a finished result
// holds in the output register and the sequencer waits before loading the next.
// Depends on iol_pkg, iol_controller, iol_datapath and iol_ram.
`default_nettype none
module indexed_ordered_list (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // tdata: position_a[4:0], position_b[8:5], item_value[40:9], zero pad
   input  wire logic [iol_pkg::REQ_DATA_W-1:0]    req_tdata,
   // tuser: req_type[2:0], zero pad
   input  wire logic [iol_pkg::REQ_USER_W-1:0]    req_tuser,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // tdata: status[1:0], read_value[33:2], match[34], entry_count[39:35],
   //        is_empty[40], zero pad
   output logic [iol_pkg::RSP_DATA_W-1:0]         rsp_tdata
);
   import iol_pkg::*;

   ctrl_cmd_type        cmd;
   dp_status_type       sts;
   logic [1:0]          rsp_status;
   logic signed [VAL_W-1:0] rsp_read_value;
   logic                rsp_match;
   logic [CNT_W-1:0]    rsp_entry_count;
   logic                rsp_is_empty;

   iol_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   iol_datapath u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_type        (req_tuser[TYPE_W-1:0]),
      .position_a      (req_tdata[4:0]),
      .position_b      (req_tdata[8:5]),
      .item_value      (req_tdata[40:9]),
      .rsp_tready      (rsp_tready),
      .rsp_valid       (rsp_tvalid),
      .rsp_status      (rsp_status),
      .rsp_read_value  (rsp_read_value),
      .rsp_match       (rsp_match),
      .rsp_entry_count (rsp_entry_count),
      .rsp_is_empty    (rsp_is_empty)
   );

   assign rsp_tdata = {7'd0, rsp_is_empty, rsp_entry_count, rsp_match,
                       rsp_read_value, rsp_status};

endmodule
`default_nettype wire

>>> rtl/iol_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module iol_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

>>> rtl/iol_datapath.sv
// Datapath of the indexed ordered list: request latch, count, walk index,
// entry RAM (iol_ram) and result register. Uses iol_pkg and the defines header.
`default_nettype none
`include "indexed_ordered_list_defines.svh"
module iol_datapath (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  iol_pkg::ctrl_cmd_type             cmd,
   output iol_pkg::dp_status_type            sts,
   input  wire logic [iol_pkg::TYPE_W-1:0]   req_type,
   input  wire logic [iol_pkg::POSA_W-1:0]   position_a,
   input  wire logic [iol_pkg::POSB_W-1:0]   position_b,
   input  wire logic signed [iol_pkg::VAL_W-1:0] item_value,
   input  wire logic                         rsp_tready,
   output logic                              rsp_valid,
   output logic [1:0]                        rsp_status,
   output logic signed [iol_pkg::VAL_W-1:0]  rsp_read_value,
   output logic                              rsp_match,
   output logic [iol_pkg::CNT_W-1:0]         rsp_entry_count,
   output logic                              rsp_is_empty
);
   import iol_pkg::*;

   op_type                   op_ff;
   logic [CNT_W-1:0]         pa_ff;
   logic [CNT_W-1:0]         pb_ff;
   logic [VAL_W-1:0]         val_ff;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [CNT_W-1:0]         idx_ff, idx_in;
   logic [VAL_W-1:0]         tmp_ff;
   status_type               status_ff, status_comb;
   logic [VAL_W-1:0]         rd_ff;
   logic                     hit_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [1:0]               rsp_status_ff;
   logic [VAL_W-1:0]         rsp_read_value_ff;
   logic                     rsp_match_ff;
   logic [CNT_W-1:0]         rsp_count_ff;

   logic                     is_insert;
   logic [CNT_W-1:0]         idx_init;
   logic [CNT_W-1:0]         idx_next;
   logic [CNT_W-1:0]         shift_src;
   logic [ADDR_W-1:0]        rd_addr;
   logic [ADDR_W-1:0]        wr_addr;
   logic [VAL_W-1:0]         wr_data;
   logic [VAL_W-1:0]         rd_data;
   logic                     wr_en;

   function automatic logic shift_more(input logic ins, input logic [CNT_W-1:0] v,
                                       input logic [CNT_W-1:0] pa,
                                       input logic [CNT_W-1:0] cnt);
      logic r;
      if (ins) begin
         r = (v != pa);
      end else begin
         r = ((v + CNT_W'(1)) != cnt);
      end
      return r;
   endfunction

   assign is_insert = (op_ff == OP_INSERT);
   assign idx_init  = is_insert ? count_ff : (op_ff == OP_REMOVE) ? pa_ff : '0;
   assign idx_next  = is_insert ? (idx_ff - CNT_W'(1)) : (idx_ff + CNT_W'(1));
   assign shift_src = idx_next;

   // Request checks, in the order the list semantics give them.
   always_comb begin
      status_comb = ST_OK;
      case (op_ff)
         OP_INSERT: begin
            if (pa_ff > count_ff) begin
               status_comb = ST_RANGE;
            end else if (count_ff >= CNT_W'(CAPACITY)) begin
               status_comb = ST_FULL;
            end
         end
         OP_SWAP: begin
            if (count_ff == '0) begin
               status_comb = ST_EMPTY;
            end else if (pa_ff >= count_ff || pb_ff >= count_ff) begin
               status_comb = ST_RANGE;
            end
         end
         OP_CLEAR: begin
            status_comb = ST_OK;
         end
         OP_SEARCH: begin
            if (count_ff == '0) begin
               status_comb = ST_EMPTY;
            end
         end
         default: begin
            if (count_ff == '0) begin
               status_comb = ST_EMPTY;
            end else if (pa_ff >= count_ff) begin
               status_comb = ST_RANGE;
            end
         end
      endcase
   end

   always_comb begin
      sts.op          = op_ff;
      sts.fail        = (status_comb != ST_OK);
      sts.shift_go    = shift_more(is_insert, idx_init, pa_ff, count_ff);
      sts.shift_again = shift_more(is_insert, idx_next, pa_ff, count_ff);
      sts.scan_again  = (idx_next != count_ff);
      sts.out_free    = !rsp_valid_ff || rsp_tready;
   end

   // RAM port selection.
   always_comb begin
      case (cmd.rd_sel)
         RS_SHIFT: rd_addr = shift_src[ADDR_W-1:0];
         RS_IDX:   rd_addr = idx_ff[ADDR_W-1:0];
         RS_PA:    rd_addr = pa_ff[ADDR_W-1:0];
         RS_PB:    rd_addr = pb_ff[ADDR_W-1:0];
         default:  rd_addr = idx_ff[ADDR_W-1:0];
      endcase
      case (cmd.wr_sel)
         WS_SHIFT: begin
            wr_addr = idx_ff[ADDR_W-1:0];
            wr_data = rd_data;
         end
         WS_PUT: begin
            wr_addr = pa_ff[ADDR_W-1:0];
            wr_data = val_ff;
         end
         WS_SWAP_A: begin
            wr_addr = pa_ff[ADDR_W-1:0];
            wr_data = rd_data;
         end
         WS_SWAP_B: begin
            wr_addr = pb_ff[ADDR_W-1:0];
            wr_data = tmp_ff;
         end
         default: begin
            wr_addr = idx_ff[ADDR_W-1:0];
            wr_data = rd_data;
         end
      endcase
      wr_en = cmd.wr_en;
   end

   iol_ram #(
      .WIDTH (VAL_W),
      .DEPTH (CAPACITY)
   ) u_entries (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      count_in = count_ff;
      if (cmd.count_clr) begin
         count_in = '0;
      end else if (cmd.count_inc) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.count_dec) begin
         count_in = count_ff - CNT_W'(1);
      end
      idx_in = idx_ff;
      if (cmd.decide) begin
         idx_in = idx_init;
      end else if (cmd.idx_step) begin
         idx_in = idx_next;
      end
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (cmd.load_req) begin
         op_ff  <= op_type'(req_type);
         pa_ff  <= CNT_W'(position_a);
         pb_ff  <= CNT_W'(position_b);
         val_ff <= item_value;
      end
      if (cmd.decide) begin
         status_ff <= status_comb;
         rd_ff     <= '0;
         hit_ff    <= 1'b0;
      end
      if (cmd.scan_update && (rd_data == val_ff)) begin
         hit_ff <= 1'b1;
      end
      if (cmd.capture) begin
         if (op_ff == OP_READ) begin
            rd_ff <= rd_data;
         end else begin
            hit_ff <= (rd_data == val_ff);
         end
      end
      if (cmd.tmp_load) begin
         tmp_ff <= rd_data;
      end
      if (cmd.out_load) begin
         rsp_status_ff     <= status_ff;
         rsp_read_value_ff <= rd_ff;
         rsp_match_ff      <= hit_ff;
         rsp_count_ff      <= count_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_read_value  = rsp_read_value_ff;
   assign rsp_match       = rsp_match_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_is_empty    = (rsp_count_ff == '0);

   `IOL_ASSERT(a_count_bound, clock, reset, count_ff <= CNT_W'(CAPACITY), "count above capacity")
   `IOL_ASSERT_IMPLY(a_write_in_list, clock, reset, wr_en, CNT_W'(wr_addr) <= count_ff, "write beyond list end")
   `IOL_ASSERT_IMPLY(a_no_overwrite, clock, reset, cmd.out_load, !rsp_valid_ff || rsp_tready, "result overwritten before taken")
   `IOL_ASSERT_IMPLY(a_count_step, clock, reset, !$past(reset) && (count_ff != $past(count_ff)), (count_ff == $past(count_ff) + CNT_W'(1)) || (count_ff == $past(count_ff) - CNT_W'(1)) || (count_ff == '0), "count jumped")

endmodule
`default_nettype wire

>>> rtl/iol_controller.sv
// Controller of the indexed ordered list: one-hot sequencer driving the
// datapath commands. Uses iol_pkg and the defines header.
`default_nettype none
`include "indexed_ordered_list_defines.svh"
module iol_controller (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  iol_pkg::dp_status_type sts,
   output iol_pkg::ctrl_cmd_type  cmd
);
   import iol_pkg::*;

   typedef enum logic [13:0] {
      S_IDLE     = 14'h0001,
      S_DECIDE   = 14'h0002,
      S_SHIFT_RD = 14'h0004,
      S_SHIFT_WR = 14'h0008,
      S_PUT      = 14'h0010,
      S_SCAN_RD  = 14'h0020,
      S_SCAN_CMP = 14'h0040,
      S_GET_RD   = 14'h0080,
      S_GET_CAP  = 14'h0100,
      S_SW_RDA   = 14'h0200,
      S_SW_RDB   = 14'h0400,
      S_SW_WRA   = 14'h0800,
      S_SW_WRB   = 14'h1000,
      S_FINISH   = 14'h2000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_req = 1'b1;
               state_in     = S_DECIDE;
            end
         end
         S_DECIDE: begin
            cmd.decide = 1'b1;
            if (sts.fail) begin
               state_in = S_FINISH;
            end else begin
               case (sts.op)
                  OP_INSERT:  state_in = sts.shift_go ? S_SHIFT_RD : S_PUT;
                  OP_REMOVE: begin
                     if (sts.shift_go) begin
                        state_in = S_SHIFT_RD;
                     end else begin
                        cmd.count_dec = 1'b1;
                        state_in      = S_FINISH;
                     end
                  end
                  OP_READ:    state_in = S_GET_RD;
                  OP_COMPARE: state_in = S_GET_RD;
                  OP_REPLACE: state_in = S_PUT;
                  OP_SEARCH:  state_in = S_SCAN_RD;
                  OP_SWAP:    state_in = S_SW_RDA;
                  OP_CLEAR: begin
                     cmd.count_clr = 1'b1;
                     state_in      = S_FINISH;
                  end
                  default:    state_in = S_FINISH;
               endcase
            end
         end
         S_SHIFT_RD: begin
            cmd.rd_sel = RS_SHIFT;
            state_in   = S_SHIFT_WR;
         end
         S_SHIFT_WR: begin
            cmd.wr_en    = 1'b1;
            cmd.wr_sel   = WS_SHIFT;
            cmd.idx_step = 1'b1;
            if (sts.shift_again) begin
               state_in = S_SHIFT_RD;
            end else if (sts.op == OP_INSERT) begin
               state_in = S_PUT;
            end else begin
               cmd.count_dec = 1'b1;
               state_in      = S_FINISH;
            end
         end
         S_PUT: begin
            cmd.wr_en     = 1'b1;
            cmd.wr_sel    = WS_PUT;
            cmd.count_inc = (sts.op == OP_INSERT);
            state_in      = S_FINISH;
         end
         S_SCAN_RD: begin
            cmd.rd_sel = RS_IDX;
            state_in   = S_SCAN_CMP;
         end
         S_SCAN_CMP: begin
            cmd.scan_update = 1'b1;
            cmd.idx_step    = 1'b1;
            state_in        = sts.scan_again ? S_SCAN_RD : S_FINISH;
         end
         S_GET_RD: begin
            cmd.rd_sel = RS_PA;
            state_in   = S_GET_CAP;
         end
         S_GET_CAP: begin
            cmd.capture = 1'b1;
            state_in    = S_FINISH;
         end
         S_SW_RDA: begin
            cmd.rd_sel = RS_PA;
            state_in   = S_SW_RDB;
         end
         S_SW_RDB: begin
            // hold entry a while entry b is fetched
            cmd.rd_sel   = RS_PB;
            cmd.tmp_load = 1'b1;
            state_in     = S_SW_WRA;
         end
         S_SW_WRA: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = WS_SWAP_A;
            state_in   = S_SW_WRB;
         end
         S_SW_WRB: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = WS_SWAP_B;
            state_in   = S_FINISH;
         end
         S_FINISH: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `IOL_ASSERT_NEXT(a_accept_decides, clock, reset, req_tvalid && req_tready, state_ff == S_DECIDE, "accepted word not decoded")
   `IOL_ASSERT_IMPLY(a_write_not_idle, clock, reset, cmd.wr_en, state_ff != S_IDLE && state_ff != S_FINISH, "RAM write outside a request")
   `IOL_ASSERT_IMPLY(a_load_in_finish, clock, reset, cmd.out_load, state_ff == S_FINISH, "result loaded before request done")

endmodule
`default_nettype wire
